// File: design/gpc_pkg.sv
// gear position classifier package: word types, register codes, constants
// and the scaling and segment helper functions
// no dependencies
package gpc_pkg;

  // widths of the fixed fields
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned CV_W     = 9;
  localparam int unsigned GEAR_W   = 3;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PHASE_W  = 3;

  // parameter defaults
  localparam int unsigned SAMPLES_PER_READING_DEF   = 16;
  localparam int unsigned READINGS_PER_DECISION_DEF = 6;

  // reset values of the running minimums
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN_RESET = 10'd1023;
  localparam logic [SAMPLE_W-1:0] WINDOW_MIN_RESET = 10'd1000;

  // neutral segment walks round a..f
  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;

  // gear codes
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;
  localparam logic [GEAR_W-1:0] GEAR_FIRST   = 3'd1;
  localparam logic [GEAR_W-1:0] GEAR_SECOND  = 3'd2;
  localparam logic [GEAR_W-1:0] GEAR_THIRD   = 3'd3;
  localparam logic [GEAR_W-1:0] GEAR_FOURTH  = 3'd4;
  localparam logic [GEAR_W-1:0] GEAR_FIFTH   = 3'd5;
  localparam logic [GEAR_W-1:0] GEAR_SIXTH   = 3'd6;

  // input op and result kind codes
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_TICK     = 1'b1;
  localparam logic KIND_GEAR   = 1'b0;
  localparam logic KIND_SEGS   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_FOURTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_FIFTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SIXTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ABOVE_THRESH  = 3'd6;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [GEAR_W-1:0] gear_code;
    logic [SEG_W-1:0]  segment_bits;
  } out_word_t;

  // classification limits, all in centivolts
  typedef struct packed {
    logic [CV_W-1:0] first;
    logic [CV_W-1:0] second;
    logic [CV_W-1:0] third;
    logic [CV_W-1:0] fourth;
    logic [CV_W-1:0] fifth;
    logic [CV_W-1:0] sixth;
    logic [CV_W-1:0] above;
  } limits_t;

  // floor(raw * 500 / 1023): 500x by shift and subtract, then the
  // divide by 2^10-1 as (n + n/1024 + 1) / 1024, exact for quotients below 1024
  function automatic logic [CV_W-1:0] scale_reading(input logic [SAMPLE_W-1:0] raw);
    logic [19:0] prod;
    logic [19:0] sum;
    prod = {1'b0, raw, 9'd0} - {7'd0, raw, 3'd0} - {8'd0, raw, 2'd0};
    sum  = prod + {10'd0, prod[19:10]} + 20'd1;
    return sum[10 +: CV_W];
  endfunction

  // seven segment pattern of a gear digit, segments a..g on bits 0..6
  function automatic logic [SEG_W-1:0] digit_segments(input logic [GEAR_W-1:0] gear);
    logic [SEG_W-1:0] seg;
    unique case (gear)
      GEAR_FIRST:  seg = 7'h06;
      GEAR_SECOND: seg = 7'h5B;
      GEAR_THIRD:  seg = 7'h4F;
      GEAR_FOURTH: seg = 7'h66;
      GEAR_FIFTH:  seg = 7'h6D;
      GEAR_SIXTH:  seg = 7'h7D;
      default:     seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: design/gpc_classify.sv
// gear classifier: compares the window minimum against the six cutoffs
// in order and reports the gear and whether the arm flag is cleared
// depends on gpc_pkg
module gpc_classify (
  input  logic [gpc_pkg::SAMPLE_W-1:0] window_min,
  input  gpc_pkg::limits_t             limits,
  input  logic                         armed,
  output logic [gpc_pkg::GEAR_W-1:0]   gear,
  output logic                         clear_arm
);
  import gpc_pkg::*;

  logic [SAMPLE_W-1:0] lim_first, lim_second, lim_third;
  logic [SAMPLE_W-1:0] lim_fourth, lim_fifth, lim_sixth;

  // widen the cutoffs to the minimum's width
  assign lim_first  = {1'b0, limits.first};
  assign lim_second = {1'b0, limits.second};
  assign lim_third  = {1'b0, limits.third};
  assign lim_fourth = {1'b0, limits.fourth};
  assign lim_fifth  = {1'b0, limits.fifth};
  assign lim_sixth  = {1'b0, limits.sixth};

  // first cutoff that holds wins, second gear only when armed
  always_comb begin
    clear_arm = 1'b0;
    priority if (window_min <= lim_first) begin
      gear      = GEAR_FIRST;
      clear_arm = 1'b1;
    end else if (window_min <= lim_second && armed) begin
      gear = GEAR_SECOND;
    end else if (window_min <= lim_third) begin
      gear = GEAR_THIRD;
    end else if (window_min <= lim_fourth) begin
      gear = GEAR_FOURTH;
    end else if (window_min <= lim_fifth) begin
      gear = GEAR_FIFTH;
    end else if (window_min <= lim_sixth) begin
      gear = GEAR_SIXTH;
    end else begin
      gear = GEAR_NEUTRAL;
    end
  end

endmodule

// File: design/gear_position_classifier.sv
// gear position classifier top level: input register, group and window
// minimum tracking, gear decision and display pattern, output register
// depends on gpc_pkg and gpc_classify
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one word per cycle while
//   in_ready is high: a converter sample (op 0) or a display tick (op 1).
//   out channel (out_valid/out_ready/out_data) gives a gear decision word
//   once per SAMPLES_PER_READING * READINGS_PER_DECISION samples (and on the
//   first reading after reset), and a segment pattern word for every tick.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six
//   cutoffs and the arm threshold; cfg_ready is always high and indexes
//   above six are dropped. Write only while the block is idle.
// Timing:
//   a word is held in the input register and is processed from there into
//   the output register; out_valid rises when the output register is
//   loaded. one word per clock sustained while out_data is taken; all state
//   updates happen in the same step that moves a word on.
// Reset (rst_n low, synchronous): limits return to their defaults, the
//   minimums return to their start values, counters, gear and neutral phase
//   are cleared, both registers empty.
// Stall: while out_data waits, the input register keeps taking words that
//   produce no result; a word that does produce one holds there, and in_ready
//   drops until the output register is taken.
module gear_position_classifier #(
  parameter int unsigned SAMPLES_PER_READING   = gpc_pkg::SAMPLES_PER_READING_DEF,
  parameter int unsigned READINGS_PER_DECISION = gpc_pkg::READINGS_PER_DECISION_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gpc_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gpc_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpc_pkg::CV_W-1:0]      cfg_data
);
  import gpc_pkg::*;

  localparam int unsigned SCNT_W = (SAMPLES_PER_READING > 1) ?
                                   $clog2(SAMPLES_PER_READING) : 1;
  localparam int unsigned RCNT_W = (READINGS_PER_DECISION > 1) ?
                                   $clog2(READINGS_PER_DECISION) : 1;
  localparam logic [SCNT_W-1:0] SCNT_LAST = SCNT_W'(SAMPLES_PER_READING - 1);
  localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(READINGS_PER_DECISION - 1);

  // configuration
  limits_t limits_r;

  // input register
  logic     in_vld_r;
  in_word_t in_word_r;

  // block state
  logic [SAMPLE_W-1:0] sample_min_r, sample_min_nxt;
  logic [SCNT_W-1:0]   sample_cnt_r, sample_cnt_nxt;
  logic [SAMPLE_W-1:0] window_min_r, window_min_nxt;
  logic [RCNT_W-1:0]   reading_cnt_r, reading_cnt_nxt;
  logic                armed_r, armed_nxt;
  logic [GEAR_W-1:0]   gear_r, gear_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;

  // output register
  logic      out_vld_r;
  out_word_t out_word_r, out_word_nxt;

  // datapath signals
  logic [SAMPLE_W-1:0] group_min;
  logic [CV_W-1:0]     reading;
  logic                armed_upd;
  logic [SAMPLE_W-1:0] wmin_upd;
  logic [GEAR_W-1:0]   decided_gear;
  logic                clear_arm;
  logic                emit;
  logic                out_free;
  logic                advance;

  // configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.first  <= 9'd156;
      limits_r.second <= 9'd213;
      limits_r.third  <= 9'd286;
      limits_r.fourth <= 9'd366;
      limits_r.fifth  <= 9'd432;
      limits_r.sixth  <= 9'd477;
      limits_r.above  <= 9'd300;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CUTOFF_FIRST:  limits_r.first  <= cfg_data;
        REG_CUTOFF_SECOND: limits_r.second <= cfg_data;
        REG_CUTOFF_THIRD:  limits_r.third  <= cfg_data;
        REG_CUTOFF_FOURTH: limits_r.fourth <= cfg_data;
        REG_CUTOFF_FIFTH:  limits_r.fifth  <= cfg_data;
        REG_CUTOFF_SIXTH:  limits_r.sixth  <= cfg_data;
        REG_ABOVE_THRESH:  limits_r.above  <= cfg_data;
        default: ;
      endcase
    end
  end

  // reading path: group minimum, scaling, arm test, window minimum
  assign group_min = (in_word_r.adc_sample < sample_min_r) ? in_word_r.adc_sample
                                                           : sample_min_r;
  assign reading   = scale_reading(group_min);
  assign armed_upd = armed_r | (reading > limits_r.above);
  assign wmin_upd  = ({1'b0, reading} < window_min_r) ? {1'b0, reading} : window_min_r;

  gpc_classify u_classify (
    .window_min (wmin_upd),
    .limits     (limits_r),
    .armed      (armed_upd),
    .gear       (decided_gear),
    .clear_arm  (clear_arm)
  );

  // next state and result word for the word in the input register
  always_comb begin
    sample_min_nxt  = sample_min_r;
    sample_cnt_nxt  = sample_cnt_r;
    window_min_nxt  = window_min_r;
    reading_cnt_nxt = reading_cnt_r;
    armed_nxt       = armed_r;
    gear_nxt        = gear_r;
    phase_nxt       = phase_r;
    emit            = 1'b0;
    out_word_nxt    = '0;
    if (in_word_r.op == OP_TICK) begin
      emit                   = 1'b1;
      out_word_nxt.kind      = KIND_SEGS;
      out_word_nxt.gear_code = gear_r;
      if (gear_r == GEAR_NEUTRAL) begin
        out_word_nxt.segment_bits = SEG_W'(1) << phase_r;
        phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + 3'd1;
      end else begin
        out_word_nxt.segment_bits = digit_segments(gear_r);
      end
    end else if (sample_cnt_r != SCNT_LAST) begin
      sample_min_nxt = group_min;
      sample_cnt_nxt = sample_cnt_r + 1'b1;
    end else begin
      sample_min_nxt  = SAMPLE_MIN_RESET;
      sample_cnt_nxt  = '0;
      reading_cnt_nxt = (reading_cnt_r == RCNT_LAST) ? '0 : reading_cnt_r + 1'b1;
      if (reading_cnt_r == '0) begin
        emit                   = 1'b1;
        gear_nxt               = decided_gear;
        armed_nxt              = armed_upd & ~clear_arm;
        window_min_nxt         = WINDOW_MIN_RESET;
        out_word_nxt.kind      = KIND_GEAR;
        out_word_nxt.gear_code = decided_gear;
      end else begin
        armed_nxt      = armed_upd;
        window_min_nxt = wmin_upd;
      end
    end
  end

  // handshake: a word without a result completes even when the output is full
  assign out_free = ~out_vld_r | out_ready;
  assign advance  = in_vld_r & (out_free | ~emit);
  assign in_ready = ~in_vld_r | advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_min_r  <= SAMPLE_MIN_RESET;
      sample_cnt_r  <= '0;
      window_min_r  <= WINDOW_MIN_RESET;
      reading_cnt_r <= '0;
      armed_r       <= 1'b0;
      gear_r        <= GEAR_NEUTRAL;
      phase_r       <= '0;
    end else if (advance) begin
      sample_min_r  <= sample_min_nxt;
      sample_cnt_r  <= sample_cnt_nxt;
      window_min_r  <= window_min_nxt;
      reading_cnt_r <= reading_cnt_nxt;
      armed_r       <= armed_nxt;
      gear_r        <= gear_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // checks on the block's own logic
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_LAST)
    else $error("neutral phase out of range");

  a_gear_word_no_segments: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_word_r.kind == KIND_GEAR |-> out_word_r.segment_bits == '0)
    else $error("gear word carries segment bits");

  a_neutral_one_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_word_r.kind == KIND_SEGS && out_word_r.gear_code == GEAR_NEUTRAL
    |-> $onehot(out_word_r.segment_bits[5:0]) && !out_word_r.segment_bits[6])
    else $error("neutral pattern not a single segment a..f");

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    gear_r <= GEAR_SIXTH)
    else $error("current gear out of range");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_word_r))
    else $error("stalled word lost from input register");

endmodule
